### rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/mbob_pkg.sv
// types, constants and helpers of the order book builder
`default_nettype none
package mbob_pkg;

    localparam int ORDER_SLOTS  = 4096;
    localparam int DEPTH_LEVELS = 8;

    localparam int ADDR_W = $clog2(ORDER_SLOTS);
    localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
    localparam int RANK_W = (DEPTH_LEVELS > 1) ? $clog2(DEPTH_LEVELS) : 1;

    localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_ADD        = 3'd0;
    localparam logic [2:0] CMD_MODIFY     = 3'd1;
    localparam logic [2:0] CMD_CANCEL     = 3'd2;
    localparam logic [2:0] CMD_TRADE      = 3'd3;
    localparam logic [2:0] CMD_SNAP_BEGIN = 3'd4;
    localparam logic [2:0] CMD_SNAP_ORDER = 3'd5;
    localparam logic [2:0] CMD_SNAP_END   = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_FAULTED = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [47:0] sequence_req;
        logic [47:0] ord_key;
        logic        order_side;
        logic [31:0] tick_price;
        logic [31:0] order_qty;
        logic [31:0] remaining_qty;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        level_side;
        logic [2:0]  level_index;
        logic [31:0] level_price;
        logic [31:0] level_qty;
        logic [31:0] last_trade_price;
        logic        book_ready;
        logic        last;
    } result_item_t;

    typedef struct packed {
        logic [47:0] ord_key;
        logic [31:0] price;
        logic [31:0] qty;
        logic        side;
    } slot_t;

    function automatic logic good32(input logic [31:0] v);
        return (v != 32'd0) && (v != MASK32);
    endfunction

endpackage
`default_nettype wire

### rtl/market_by_order_book_builder_unit.sv
// top level of the market-by-order book builder
`default_nettype none
`include "assert_macros.svh"

// market-by-order book builder. one item is taken when start is high and busy
// is low; its results come on result_item with result_valid, one per cycle,
// and the receiver cannot stall them. items that answer with a single result
// (stale, ignored, immediate faults, snapshot begin, a faulted book) give
// their result in the cycle after acceptance. resting orders are kept packed
// in a slot memory with one read and one write port at indexes 0..held-1, so
// every order lookup is a linear walk over the held orders, a cancel then
// reads the last order and writes it into the hole, and a book publication
// walks the memory once per level rank for both sides at once, then emits
// DEPTH_LEVELS results per side. there is no clearing pass after reset:
// emptying the book only zeroes the held count. configuration is always
// ready and must be written only while the block is idle; the block itself
// does not enforce this.
module market_by_order_book_builder_unit (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire mbob_pkg::in_item_t in_item,
    output logic                  result_valid,
    output mbob_pkg::result_item_t result_item,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [12:0]           cfg_data
);
    import mbob_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_ACT  = 8'b0000_0100,
        S_CRD  = 8'b0000_1000,
        S_CWR  = 8'b0001_0000,
        S_FIN  = 8'b0010_0000,
        S_PUB  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    // slot memory, one read port with registered data
    slot_t slot_mem [ORDER_SLOTS];
    slot_t rd_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic  wr_en;
    slot_t wr_data;

    state_t state_reg, state_next;
    in_item_t req_reg, req_next;
    logic [12:0] cap_reg, cap_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic synced_reg, synced_next;
    logic snap_reg, snap_next;
    logic [47:0] feed_reg, feed_next;
    logic [47:0] wm_reg, wm_next;
    logic [31:0] trade_reg, trade_next;
    logic fault_reg, fault_next;

    // walk control
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic rv_reg, rv_next;
    logic [ADDR_W-1:0] ridx_reg, ridx_next;
    logic found_reg, found_next;
    logic [ADDR_W-1:0] fidx_reg, fidx_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic eside_reg, eside_next;
    logic over_reg, over_next;

    // per-side level search, index 0 bids and 1 asks
    logic [1:0] pfound_reg, pfound_next;
    logic [1:0] hprev_reg, hprev_next;
    logic [1:0] pdone_reg, pdone_next;
    logic [31:0] best_reg [2];
    logic [31:0] best_next [2];
    logic [31:0] sum_reg [2];
    logic [31:0] sum_next [2];
    logic [31:0] prev_reg [2];
    logic [31:0] prev_next [2];
    logic [31:0] lp_reg [2][DEPTH_LEVELS];
    logic [31:0] lp_next [2][DEPTH_LEVELS];
    logic [31:0] lq_reg [2][DEPTH_LEVELS];
    logic [31:0] lq_next [2][DEPTH_LEVELS];

    logic out_valid_reg, out_valid_next;
    result_item_t out_reg, out_next;

    logic pass_done;
    assign pass_done = (addr_reg == count_reg) && !rv_reg;
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    function automatic result_item_t single(input logic [1:0] st, input logic [31:0] tp);
        result_item_t r;
        r = '0;
        r.status = st;
        r.last_trade_price = tp;
        r.last = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        logic fault_now;
        logic pub_init;
        logic scan_init;
        logic s;
        logic [31:0] p;
        logic skip;
        logic better;
        logic [32:0] sum_w;
        logic over_w;
        state_next = state_reg;
        req_next = req_reg;
        cap_next = cap_reg;
        count_next = count_reg;
        synced_next = synced_reg;
        snap_next = snap_reg;
        feed_next = feed_reg;
        wm_next = wm_reg;
        trade_next = trade_reg;
        fault_next = fault_reg;
        addr_next = addr_reg;
        rv_next = 1'b0;
        ridx_next = ridx_reg;
        found_next = found_reg;
        fidx_next = fidx_reg;
        rank_next = rank_reg;
        eside_next = eside_reg;
        over_next = over_reg;
        pfound_next = pfound_reg;
        hprev_next = hprev_reg;
        pdone_next = pdone_reg;
        best_next = best_reg;
        sum_next = sum_reg;
        prev_next = prev_reg;
        lp_next = lp_reg;
        lq_next = lq_reg;
        out_valid_next = 1'b0;
        out_next = out_reg;
        rd_addr = addr_reg[ADDR_W-1:0];
        wr_en = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = '0;
        fault_now = 1'b0;
        pub_init = 1'b0;
        scan_init = 1'b0;
        s = 1'b0;
        p = '0;
        skip = 1'b0;
        better = 1'b0;
        sum_w = '0;
        over_w = over_reg;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        // memory walk shared by lookup and publication
        if (state_reg == S_SCAN || state_reg == S_PUB)
        begin
            if (addr_reg < count_reg)
            begin
                rv_next = 1'b1;
                ridx_next = addr_reg[ADDR_W-1:0];
                addr_next = addr_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = in_item;
                    if (fault_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next = single(ST_FAULTED, trade_reg);
                    end
                    else
                    begin
                        case (in_item.cmd)
                            CMD_SNAP_BEGIN:
                            begin
                                out_valid_next = 1'b1;
                                if (synced_reg)
                                begin
                                    out_next = single(ST_IGNORED, trade_reg);
                                end
                                else
                                begin
                                    count_next = '0;
                                    snap_next = 1'b1;
                                    wm_next = in_item.sequence_req;
                                    out_next = single(ST_OK, trade_reg);
                                end
                            end
                            CMD_SNAP_ORDER, CMD_SNAP_END:
                            begin
                                if (!snap_reg)
                                begin
                                    if (synced_reg)
                                    begin
                                        out_valid_next = 1'b1;
                                        out_next = single(ST_IGNORED, trade_reg);
                                    end
                                    else
                                    begin
                                        fault_now = 1'b1;
                                    end
                                end
                                else if (in_item.cmd == CMD_SNAP_END)
                                begin
                                    snap_next = 1'b0;
                                    synced_next = 1'b1;
                                    feed_next = wm_reg;
                                    pub_init = 1'b1;
                                end
                                else if (in_item.sequence_req == 48'd0
                                         || in_item.sequence_req > wm_reg
                                         || !good32(in_item.tick_price)
                                         || in_item.ord_key == 48'd0
                                         || !good32(in_item.order_qty))
                                begin
                                    fault_now = 1'b1;
                                end
                                else
                                begin
                                    scan_init = 1'b1;
                                end
                            end
                            CMD_ADD, CMD_MODIFY, CMD_CANCEL, CMD_TRADE:
                            begin
                                if (!synced_reg || in_item.sequence_req <= wm_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = single(ST_IGNORED, trade_reg);
                                end
                                else if (in_item.sequence_req != feed_reg + 48'd1)
                                begin
                                    fault_now = 1'b1;
                                end
                                else if (!good32(in_item.tick_price)
                                         || (in_item.cmd != CMD_TRADE
                                             && in_item.ord_key == 48'd0))
                                begin
                                    fault_now = 1'b1;
                                end
                                else if ((in_item.cmd == CMD_ADD
                                          && !good32(in_item.order_qty))
                                         || (in_item.cmd == CMD_MODIFY
                                          && !good32(in_item.remaining_qty))
                                         || (in_item.cmd == CMD_TRADE
                                          && !good32(in_item.order_qty)))
                                begin
                                    fault_now = 1'b1;
                                end
                                else if (in_item.cmd == CMD_TRADE)
                                begin
                                    // the trade price stands even if the capacity check faults
                                    trade_next = in_item.tick_price;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    scan_init = 1'b1;
                                end
                            end
                            default:
                            begin
                                fault_now = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (rv_reg && rd_reg.ord_key == req_reg.ord_key)
                begin
                    found_next = 1'b1;
                    fidx_next = ridx_reg;
                end
                if (pass_done)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                case (req_reg.cmd)
                    CMD_ADD, CMD_SNAP_ORDER:
                    begin
                        if (found_reg || count_reg == CNT_W'(ORDER_SLOTS))
                        begin
                            fault_now = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            wr_addr = count_reg[ADDR_W-1:0];
                            wr_data.ord_key = req_reg.ord_key;
                            wr_data.price = req_reg.tick_price;
                            wr_data.qty = req_reg.order_qty;
                            wr_data.side = req_reg.order_side;
                            count_next = count_reg + CNT_W'(1);
                            if (req_reg.cmd == CMD_ADD)
                            begin
                                state_next = S_FIN;
                            end
                            else if (32'(count_reg) + 32'd1 > 32'(cap_reg))
                            begin
                                fault_now = 1'b1;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_next = single(ST_OK, trade_reg);
                            end
                        end
                    end
                    CMD_MODIFY:
                    begin
                        if (!found_reg)
                        begin
                            fault_now = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            wr_addr = fidx_reg;
                            wr_data.ord_key = req_reg.ord_key;
                            wr_data.price = req_reg.tick_price;
                            wr_data.qty = req_reg.remaining_qty;
                            wr_data.side = req_reg.order_side;
                            state_next = S_FIN;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (!found_reg)
                        begin
                            fault_now = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CRD;
                        end
                    end
                    default:
                    begin
                        fault_now = 1'b1;
                    end
                endcase
            end
            S_CRD:
            begin
                // fetch the last order to fill the hole
                rd_addr = ADDR_W'(count_reg - CNT_W'(1));
                state_next = S_CWR;
            end
            S_CWR:
            begin
                wr_en = 1'b1;
                wr_addr = fidx_reg;
                wr_data = rd_reg;
                count_next = count_reg - CNT_W'(1);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (32'(count_reg) > 32'(cap_reg))
                begin
                    fault_now = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    feed_next = req_reg.sequence_req;
                    pub_init = 1'b1;
                end
            end
            S_PUB:
            begin
                if (rv_reg)
                begin
                    s = rd_reg.side;
                    p = rd_reg.price;
                    skip = pdone_reg[s]
                        || (hprev_reg[s] && (s ? (p <= prev_reg[s]) : (p >= prev_reg[s])));
                    better = !pfound_reg[s] || (s ? (p < best_reg[s]) : (p > best_reg[s]));
                    sum_w = {1'b0, sum_reg[s]} + {1'b0, rd_reg.qty};
                    if (!skip)
                    begin
                        if (better)
                        begin
                            pfound_next[s] = 1'b1;
                            best_next[s] = p;
                            sum_next[s] = rd_reg.qty;
                        end
                        else if (p == best_reg[s])
                        begin
                            sum_next[s] = (sum_w >= {1'b0, MASK32}) ? MASK32 : sum_w[31:0];
                        end
                    end
                end
                if (pass_done)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (!pdone_reg[i] && pfound_reg[i])
                        begin
                            lp_next[i][rank_reg] = best_reg[i];
                            lq_next[i][rank_reg] = sum_reg[i];
                            prev_next[i] = best_reg[i];
                            hprev_next[i] = 1'b1;
                            if (sum_reg[i] == MASK32)
                            begin
                                over_w = 1'b1;
                            end
                        end
                        else
                        begin
                            pdone_next[i] = 1'b1;
                        end
                    end
                    over_next = over_w;
                    pfound_next = '0;
                    addr_next = '0;
                    rv_next = 1'b0;
                    if (rank_reg == RANK_W'(DEPTH_LEVELS - 1))
                    begin
                        rank_next = '0;
                        eside_next = 1'b0;
                        state_next = S_EMIT;
                        if (over_w)
                        begin
                            fault_next = 1'b1;
                        end
                    end
                    else
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                end
            end
            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_next.status = over_reg ? ST_FAULT : ST_OK;
                out_next.level_side = eside_reg;
                out_next.level_index = 3'(rank_reg);
                out_next.level_price = lp_reg[eside_reg][rank_reg];
                out_next.level_qty = lq_reg[eside_reg][rank_reg];
                out_next.last_trade_price = trade_reg;
                out_next.book_ready = (lq_reg[0][0] != 32'd0) && (lq_reg[1][0] != 32'd0)
                                      && (lp_reg[0][0] < lp_reg[1][0]);
                out_next.last = eside_reg && (rank_reg == RANK_W'(DEPTH_LEVELS - 1));
                if (rank_reg == RANK_W'(DEPTH_LEVELS - 1))
                begin
                    rank_next = '0;
                    eside_next = 1'b1;
                    if (eside_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fault_now)
        begin
            fault_next = 1'b1;
            out_valid_next = 1'b1;
            out_next = single(ST_FAULT, trade_next);
            state_next = S_IDLE;
        end
        if (scan_init)
        begin
            addr_next = '0;
            rv_next = 1'b0;
            found_next = 1'b0;
            state_next = S_SCAN;
        end
        if (pub_init)
        begin
            addr_next = '0;
            rv_next = 1'b0;
            rank_next = '0;
            over_next = 1'b0;
            pfound_next = '0;
            hprev_next = '0;
            pdone_next = '0;
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < DEPTH_LEVELS; j++)
                begin
                    lp_next[i][j] = '0;
                    lq_next[i][j] = '0;
                end
            end
            state_next = S_PUB;
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_reg <= slot_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= 13'd4096;
            count_reg <= '0;
            synced_reg <= 1'b0;
            snap_reg <= 1'b0;
            feed_reg <= '0;
            wm_reg <= '0;
            trade_reg <= '0;
            fault_reg <= 1'b0;
            addr_reg <= '0;
            rv_reg <= 1'b0;
            found_reg <= 1'b0;
            rank_reg <= '0;
            eside_reg <= 1'b0;
            over_reg <= 1'b0;
            pfound_reg <= '0;
            hprev_reg <= '0;
            pdone_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg <= cap_next;
            count_reg <= count_next;
            synced_reg <= synced_next;
            snap_reg <= snap_next;
            feed_reg <= feed_next;
            wm_reg <= wm_next;
            trade_reg <= trade_next;
            fault_reg <= fault_next;
            addr_reg <= addr_next;
            rv_reg <= rv_next;
            found_reg <= found_next;
            rank_reg <= rank_next;
            eside_reg <= eside_next;
            over_reg <= over_next;
            pfound_reg <= pfound_next;
            hprev_reg <= hprev_next;
            pdone_reg <= pdone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        ridx_reg <= ridx_next;
        fidx_reg <= fidx_next;
        best_reg <= best_next;
        sum_reg <= sum_next;
        prev_reg <= prev_next;
        lp_reg <= lp_next;
        lq_reg <= lq_next;
        out_reg <= out_next;
    end

    // held orders never exceed the slot memory
    `ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= 32'(ORDER_SLOTS))
    // the fault stays until reset
    `ASSERT_NEXT(a_fault_sticky, fault_reg, fault_reg)
    // a result burst runs without gaps up to its last item
    `ASSERT_NEXT(a_burst_contiguous, result_valid && !result_item.last, result_valid)
    // an accepted item either answers next cycle or keeps the block busy
    `ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid)

endmodule
`default_nettype wire
